// ----- rtl/tss_pkg.sv -----
`timescale 1ns / 1ps

package tss_pkg;

   // Temperature samples in 0.1 degree units, limited to +/-100.0 degrees.
   localparam int TEMP_W     = 11;
   localparam int TEMP_LIMIT = 1000;
   // Square of a limited sample: at most 1000000, below 2^20.
   localparam int SMP_SQ_W   = 20;

   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_ADD         = 2'd0;
   localparam logic [OP_W-1:0] OP_RESET_STATS = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_HIST  = 2'd2;

   localparam int COUNT_W  = 32;
   // The mean never exceeds 1000 in magnitude, so 11 quotient bits suffice.
   localparam int MEAN_Q_W = 11;
   // The running sum stays below 1000 * 2^32 in magnitude: 42 bits plus sign.
   localparam int SUM_W    = COUNT_W + MEAN_Q_W;

   localparam int STAB_W     = 14;
   localparam int FILL_OUT_W = 8;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 3;

   localparam int HISTORY_DEPTH_DEF = 128;
   localparam int WINDOW_LEN_DEF    = 100;
   localparam int MIN_SAMPLES_DEF   = 10;

   function automatic int win_min(int a, int b);
      return (a < b) ? a : b;
   endfunction

   // Width of the window sample count, which runs up to the window length.
   function automatic int cnt_width(int win);
      return $clog2(win + 1);
   endfunction

   // Signed width of the sum of one full window of samples.
   function automatic int wsum_width(int win);
      return $clog2(longint'(win) * TEMP_LIMIT + 1) + 1;
   endfunction

   // Width of the sum of squares of one full window of samples.
   function automatic int wsq_width(int win);
      return $clog2(longint'(win) * TEMP_LIMIT * TEMP_LIMIT + 1);
   endfunction

endpackage

// ----- rtl/tss_stat_math.sv -----
`timescale 1ns / 1ps

module tss_stat_math
   import tss_pkg::*;
#(
   parameter int EFF_WINDOW = win_min(WINDOW_LEN_DEF, HISTORY_DEPTH_DEF),
   localparam int N_W  = cnt_width(EFF_WINDOW),
   localparam int WS_W = wsum_width(EFF_WINDOW),
   localparam int WQ_W = wsq_width(EFF_WINDOW)
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start_i,
   input  logic signed [SUM_W-1:0]  sum_i,
   input  logic [COUNT_W-1:0]       count_i,
   input  logic signed [WS_W-1:0]   wsum_i,
   input  logic [WQ_W-1:0]          wsq_i,
   input  logic [N_W-1:0]           n_i,
   output logic                     done_o,
   output logic signed [TEMP_W-1:0] mean_o,
   output logic [STAB_W-1:0]        stab_o
);

   localparam int MAG_W    = WS_W - 1;
   localparam int PA_W     = N_W + WQ_W;
   localparam int PB_W     = 2 * MAG_W;
   localparam int D_W      = (PA_W > PB_W) ? PA_W : PB_W;
   localparam int ROOT_W   = (D_W + 8) / 2;
   localparam int SQ_W     = 2 * ROOT_W;
   localparam int MREM_W   = SUM_W - 1;
   localparam int STEP_MAX = (ROOT_W > MEAN_Q_W) ? ROOT_W : MEAN_Q_W;
   localparam int STEP_W   = $clog2(STEP_MAX + 1);

   localparam int PH_W = 3;
   localparam logic [PH_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PH_W-1:0] PH_MEAN  = 3'd1;
   localparam logic [PH_W-1:0] PH_MUL   = 3'd2;
   localparam logic [PH_W-1:0] PH_SUB   = 3'd3;
   localparam logic [PH_W-1:0] PH_SCALE = 3'd4;
   localparam logic [PH_W-1:0] PH_SQRT  = 3'd5;
   localparam logic [PH_W-1:0] PH_DIV   = 3'd6;

   logic [PH_W-1:0]     phase_ff, phase_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                done_ff, done_in;
   logic [MREM_W-1:0]   mrem_ff, mrem_in;
   logic [MREM_W-1:0]   mdsr_ff, mdsr_in;
   logic [MEAN_Q_W-1:0] mq_ff, mq_in;
   logic                mneg_ff, mneg_in;
   logic [MAG_W-1:0]    s1mag_ff, s1mag_in;
   logic [WQ_W-1:0]     wsq_ff, wsq_in;
   logic [N_W-1:0]      n_ff, n_in;
   logic [D_W-1:0]      pa_ff, pa_in;
   logic [D_W-1:0]      pb_ff, pb_in;
   logic [D_W-1:0]      d_ff, d_in;
   logic [SQ_W-1:0]     x_ff, x_in;
   logic [SQ_W-1:0]     r_ff, r_in;
   logic [SQ_W-1:0]     b_ff, b_in;
   logic [N_W-1:0]      drem_ff, drem_in;

   logic [SUM_W-1:0]    sum_abs;
   logic [WS_W-1:0]     wsum_abs;
   logic [SQ_W-1:0]     trial;
   logic [N_W:0]        rem_sh;
   logic [SQ_W-1:0]     d_ext;
   logic [MEAN_Q_W:0]   mq_ext;
   logic [MEAN_Q_W:0]   mq_neg;

   assign sum_abs  = sum_i[SUM_W-1] ? -sum_i : sum_i;
   assign wsum_abs = wsum_i[WS_W-1] ? -wsum_i : wsum_i;
   assign trial    = r_ff + b_ff;
   assign rem_sh   = {drem_ff, r_ff[ROOT_W-1]};
   assign d_ext    = SQ_W'(d_ff);

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      done_in  = done_ff;
      mrem_in  = mrem_ff;
      mdsr_in  = mdsr_ff;
      mq_in    = mq_ff;
      mneg_in  = mneg_ff;
      s1mag_in = s1mag_ff;
      wsq_in   = wsq_ff;
      n_in     = n_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      d_in     = d_ff;
      x_in     = x_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      drem_in  = drem_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start_i) begin
               mrem_in  = sum_abs[MREM_W-1:0];
               mdsr_in  = {count_i, {(MEAN_Q_W-1){1'b0}}};
               mneg_in  = sum_i[SUM_W-1];
               mq_in    = '0;
               s1mag_in = wsum_abs[MAG_W-1:0];
               wsq_in   = wsq_i;
               n_in     = n_i;
               done_in  = 1'b0;
               step_in  = '0;
               phase_in = PH_MEAN;
            end
         end
         PH_MEAN: begin
            // One quotient bit per cycle, divisor pre-shifted to the top bit.
            if (mrem_ff >= mdsr_ff) begin
               mrem_in = mrem_ff - mdsr_ff;
               mq_in   = {mq_ff[MEAN_Q_W-2:0], 1'b1};
            end else begin
               mq_in   = {mq_ff[MEAN_Q_W-2:0], 1'b0};
            end
            mdsr_in = mdsr_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MEAN_Q_W - 1)) begin
               step_in  = '0;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            pa_in    = D_W'(n_ff) * D_W'(wsq_ff);
            pb_in    = D_W'(s1mag_ff) * D_W'(s1mag_ff);
            phase_in = PH_SUB;
         end
         PH_SUB: begin
            d_in     = (pa_ff > pb_ff) ? pa_ff - pb_ff : '0;
            phase_in = PH_SCALE;
         end
         PH_SCALE: begin
            x_in     = (d_ext << 6) + (d_ext << 5) + (d_ext << 2);
            r_in     = '0;
            b_in     = SQ_W'(1) << (SQ_W - 2);
            drem_in  = '0;
            step_in  = '0;
            phase_in = PH_SQRT;
         end
         PH_SQRT: begin
            if (x_ff >= trial) begin
               x_in = x_ff - trial;
               r_in = (r_ff >> 1) + b_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            b_in    = b_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               step_in  = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            // The root shifts out at the top while the quotient fills in below.
            if (rem_sh >= {1'b0, n_ff}) begin
               drem_in = N_W'(rem_sh - {1'b0, n_ff});
               r_in    = SQ_W'({r_ff[ROOT_W-2:0], 1'b1});
            end else begin
               drem_in = rem_sh[N_W-1:0];
               r_in    = SQ_W'({r_ff[ROOT_W-2:0], 1'b0});
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               step_in  = '0;
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mrem_ff  <= mrem_in;
      mdsr_ff  <= mdsr_in;
      mq_ff    <= mq_in;
      mneg_ff  <= mneg_in;
      s1mag_ff <= s1mag_in;
      wsq_ff   <= wsq_in;
      n_ff     <= n_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      d_ff     <= d_in;
      x_ff     <= x_in;
      r_ff     <= r_in;
      b_ff     <= b_in;
      drem_ff  <= drem_in;
   end

   assign mq_ext = {1'b0, mq_ff};
   assign mq_neg = -mq_ext;
   assign done_o = done_ff;
   assign mean_o = TEMP_W'(mneg_ff ? mq_neg : mq_ext);
   assign stab_o = STAB_W'(r_ff[ROOT_W-1:0]);

endmodule

// ----- rtl/temperature_stats_and_stability.sv -----
`timescale 1ns / 1ps

// Temperature statistics and stability. Each request transaction carries an
// operation in req_tuser (add a sample, reset the statistics, clear the
// history) and a sample in 0.1 degree units in req_tdata; samples beyond
// +/-100.0 degrees are limited to that bound. Each request yields exactly one
// response transaction describing the state after the operation: running
// minimum, maximum and truncated mean since the last statistics reset, the
// history fill level, and the standard deviation over the newest samples of
// the history window in 0.01 degree units, computed as
// floor(isqrt(100*(N*S2 - S1^2)) / N). The block handles one transaction at a
// time; each runs a serial divide for the mean, then a serial square root and
// a serial divide by N, one bit per cycle each. The history lives in a
// single-port synchronous memory: the sample leaving the window is read in
// the acceptance cycle and the new sample is written in the cycle after. No
// clearing pass is needed after reset; unwritten history entries are never
// used. A finished response waits in an output register, so a new request
// may be accepted while it is still pending.
module temperature_stats_and_stability
   import tss_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int WINDOW_LEN    = WINDOW_LEN_DEF,
   parameter int MIN_SAMPLES   = MIN_SAMPLES_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [10:0] sample
   input  logic [REQ_USER_W-1:0] req_tuser,  // [1:0] operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [10:0] min_temp, [21:11] max_temp, [32:22] mean_temp,
   // [46:33] stability, [54:47] history_fill, [55] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] stats_empty, [1] stability_valid, [2] count_saturated
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int EFF_WINDOW = win_min(WINDOW_LEN, HISTORY_DEPTH);
   localparam int HEAD_W     = $clog2(HISTORY_DEPTH);
   localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);
   localparam int N_W        = cnt_width(EFF_WINDOW);
   localparam int WS_W       = wsum_width(EFF_WINDOW);
   localparam int WQ_W       = wsq_width(EFF_WINDOW);

   localparam logic signed [TEMP_W-1:0] TEMP_MAX = TEMP_W'(TEMP_LIMIT);
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = TEMP_W'(-TEMP_LIMIT);
   localparam logic [COUNT_W-1:0]       COUNT_MAX = '1;

   // Control sequence: take a transaction, apply it to the state, start the
   // arithmetic unit, then wait for it and for room in the output register.
   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
   localparam logic [ST_W-1:0] ST_UPDATE = 2'd1;
   localparam logic [ST_W-1:0] ST_CALC   = 2'd2;
   localparam logic [ST_W-1:0] ST_WAIT   = 2'd3;

   logic [ST_W-1:0]            state_ff, state_in;
   logic [OP_W-1:0]            op_ff, op_in;
   logic signed [TEMP_W-1:0]   smp_ff, smp_in;
   logic [SMP_SQ_W-1:0]        sq_new_ff, sq_new_in;
   logic signed [TEMP_W-1:0]   min_ff, min_in;
   logic signed [TEMP_W-1:0]   max_ff, max_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [HEAD_W-1:0]          head_ff, head_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic signed [WS_W-1:0]     wsum_ff, wsum_in;
   logic [WQ_W-1:0]            wsq_ff, wsq_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]      rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_W-1:0]      rsp_tuser_ff, rsp_tuser_in;

   // History ring, one sample per entry.
   logic [TEMP_W-1:0]          hist_mem [HISTORY_DEPTH];
   logic signed [TEMP_W-1:0]   rd_data_ff;
   logic                       mem_we;

   logic                       req_accept;
   logic signed [TEMP_W-1:0]   req_sample;
   logic signed [TEMP_W-1:0]   smp_clamped;
   logic signed [2*TEMP_W-1:0] smp_prod;
   logic signed [2*TEMP_W-1:0] old_prod;
   logic [HEAD_W:0]            head_ext;
   logic [HEAD_W-1:0]          old_idx;
   logic                       evict;
   logic signed [WS_W-1:0]     smp_ext;
   logic signed [WS_W-1:0]     old_ext;
   logic [N_W-1:0]             win_n;
   logic                       math_start;
   logic                       math_done;
   logic signed [TEMP_W-1:0]   math_mean;
   logic [STAB_W-1:0]          math_stab;
   logic                       rsp_free;
   logic                       rsp_load;
   logic                       stats_empty;
   logic                       stab_valid;
   logic [STAB_W-1:0]          stab_out;
   logic signed [TEMP_W-1:0]   mean_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_sample = req_tdata[TEMP_W-1:0];

   always_comb begin
      if (req_sample > TEMP_MAX) begin
         smp_clamped = TEMP_MAX;
      end else if (req_sample < TEMP_MIN) begin
         smp_clamped = TEMP_MIN;
      end else begin
         smp_clamped = req_sample;
      end
   end

   assign smp_prod = smp_clamped * smp_clamped;
   assign old_prod = rd_data_ff * rd_data_ff;

   // Entry that drops out of the window when the new sample goes in.
   assign head_ext = {1'b0, head_ff};
   always_comb begin
      if (head_ext >= (HEAD_W + 1)'(EFF_WINDOW)) begin
         old_idx = HEAD_W'(head_ext - (HEAD_W + 1)'(EFF_WINDOW));
      end else begin
         old_idx = HEAD_W'(head_ext + (HEAD_W + 1)'(HISTORY_DEPTH - EFF_WINDOW));
      end
   end

   assign evict   = (fill_ff >= FILL_W'(EFF_WINDOW));
   assign smp_ext = {{(WS_W-TEMP_W){smp_ff[TEMP_W-1]}}, smp_ff};
   assign old_ext = {{(WS_W-TEMP_W){rd_data_ff[TEMP_W-1]}}, rd_data_ff};
   assign win_n   = evict ? N_W'(EFF_WINDOW) : N_W'(fill_ff);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      smp_in    = smp_ff;
      sq_new_in = sq_new_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      wsum_in   = wsum_ff;
      wsq_in    = wsq_ff;
      mem_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_tuser[OP_W-1:0];
               smp_in    = smp_clamped;
               sq_new_in = smp_prod[SMP_SQ_W-1:0];
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            unique case (op_ff)
               OP_ADD: begin
                  mem_we = 1'b1;
                  if (evict) begin
                     wsum_in = wsum_ff - old_ext + smp_ext;
                     wsq_in  = wsq_ff - WQ_W'(old_prod[SMP_SQ_W-1:0]) + WQ_W'(sq_new_ff);
                  end else begin
                     wsum_in = wsum_ff + smp_ext;
                     wsq_in  = wsq_ff + WQ_W'(sq_new_ff);
                  end
                  head_in = (head_ff == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  if (fill_ff != FILL_W'(HISTORY_DEPTH)) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  if (smp_ff < min_ff) begin
                     min_in = smp_ff;
                  end
                  if (smp_ff > max_ff) begin
                     max_in = smp_ff;
                  end
                  // Once the count saturates the sum is frozen with it.
                  if (count_ff != COUNT_MAX) begin
                     sum_in   = sum_ff + SUM_W'(smp_ff);
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_RESET_STATS: begin
                  min_in   = TEMP_MAX;
                  max_in   = TEMP_MIN;
                  sum_in   = '0;
                  count_in = '0;
               end
               OP_CLEAR_HIST: begin
                  head_in = '0;
                  fill_in = '0;
                  wsum_in = '0;
                  wsq_in  = '0;
               end
               default: ;
            endcase
            state_in = ST_CALC;
         end
         ST_CALC: state_in = ST_WAIT;
         ST_WAIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_ff   <= TEMP_MAX;
         max_ff   <= TEMP_MIN;
         sum_ff   <= '0;
         count_ff <= '0;
         head_ff  <= '0;
         fill_ff  <= '0;
         wsum_ff  <= '0;
         wsq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         wsum_ff  <= wsum_in;
         wsq_ff   <= wsq_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      smp_ff    <= smp_in;
      sq_new_ff <= sq_new_in;
   end

   // The read of the leaving sample happens at acceptance, while the head
   // still points at the slot the new sample will take.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[head_ff] <= smp_ff;
      end
      if (req_accept) begin
         rd_data_ff <= hist_mem[old_idx];
      end
   end

   assign math_start = (state_ff == ST_CALC);

   tss_stat_math #(
      .EFF_WINDOW (EFF_WINDOW)
   ) u_math (
      .clock   (clock),
      .reset   (reset),
      .start_i (math_start),
      .sum_i   (sum_ff),
      .count_i (count_ff),
      .wsum_i  (wsum_ff),
      .wsq_i   (wsq_ff),
      .n_i     (win_n),
      .done_o  (math_done),
      .mean_o  (math_mean),
      .stab_o  (math_stab)
   );

   assign stats_empty = (count_ff == '0);
   assign stab_valid  = (fill_ff >= FILL_W'(MIN_SAMPLES));
   assign stab_out    = stab_valid ? math_stab : '0;
   assign mean_out    = stats_empty ? '0 : math_mean;

   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load = (state_ff == ST_WAIT) && math_done && rsp_free;

   always_comb begin
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      if (rsp_load) begin
         rsp_tdata_in = {1'b0, FILL_OUT_W'(fill_ff), stab_out, mean_out, max_ff, min_ff};
         rsp_tuser_in = {(count_ff == COUNT_MAX), stab_valid, stats_empty};
      end
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef ASSERT_OFF
   // Until the ring wraps, the write pointer equals the number of samples held.
   a_head_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff < FILL_W'(HISTORY_DEPTH)) |-> (FILL_W'(head_ff) == fill_ff))
      else $error("history head and fill level disagree");

   // An empty history must leave no residue in the window sums.
   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wsum_ff == '0 && wsq_ff == '0))
      else $error("window sums not zero with empty history");

   // With no counted sample the statistics are at their reset values.
   a_empty_stats: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0 && min_ff == TEMP_MAX && max_ff == TEMP_MIN))
      else $error("statistics not at reset values with zero count");

   // Every counted sample lies between the tracked extremes, so min <= max.
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("minimum above maximum");

   // Adding a sample to a history that is not full grows it by exactly one.
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && op_ff == OP_ADD && fill_ff != FILL_W'(HISTORY_DEPTH))
      |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("history fill did not advance on a sample");
`endif

endmodule
